/* rtl/core/lgce_pkg.sv */
// ----------------------------------------------------------------------------
// LED group cross-fade engine package
// Shared sizes, register indexes and control structures.
// ----------------------------------------------------------------------------
package lgce_pkg;

  localparam int NumPixels = 16;
  localparam int NumGroups = 4;
  localparam int PixW      = $clog2(NumPixels);
  localparam int GrpW      = $clog2(NumGroups);

  localparam logic [2:0] REG_BASE_ORDER = 3'd0;
  localparam logic [2:0] REG_FADE_STEP  = 3'd1;
  localparam logic [2:0] REG_DELAY      = 3'd2;
  localparam logic [2:0] REG_MAX_BRIGHT = 3'd3;
  localparam logic [2:0] REG_MIN_BRIGHT = 3'd4;
  localparam logic [2:0] REG_PIXEL_CNT  = 3'd5;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_ACTIVE = 2'd1;
  localparam logic [1:0] OP_COLOR  = 2'd2;
  localparam logic [1:0] OP_LOAD   = 2'd3;

  // Pass kinds run by the pixel sweep.
  typedef enum logic [1:0] {
    PASS_BUILD,
    PASS_BLEND,
    PASS_FINAL
  } pass_t;

  // Sweep request from the controller to the pixel engine.
  typedef struct packed {
    logic       start;
    pass_t      kind;
    logic [7:0] bright;
    logic [8:0] fade;
    logic [6:0] count;
  } sweep_req_t;

  // Divide a 16-bit product by 255 with floor.
  function automatic logic [7:0] div255(input logic [15:0] v);
    logic [16:0] q;
    begin
      q = ({1'b0, v} + 17'd1 + {9'd0, v[15:8]}) >> 8;
      div255 = q[7:0];
    end
  endfunction

endpackage

/* rtl/core/lgce_pix.sv */
// ----------------------------------------------------------------------------
// LED group cross-fade pixel engine
// Holds pixel memories and sweeps them one pixel at a time to build
// targets or emit blended and final frames.
// ----------------------------------------------------------------------------
module lgce_pix (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lgce_pkg::sweep_req_t        req,
  input  logic                        load_we,
  input  logic [lgce_pkg::PixW-1:0]   load_idx,
  input  logic [3:0]                  load_grp,
  input  logic [7:0]                  load_prof,
  input  logic                        col_we,
  input  logic [lgce_pkg::GrpW-1:0]   col_idx,
  input  logic [23:0]                 col_data,
  output logic                        busy,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [5:0]                  out_pixel,
  output logic [7:0]                  out_red,
  output logic [7:0]                  out_green,
  output logic [7:0]                  out_blue,
  output logic                        frame_last
);

  localparam int PW = lgce_pkg::PixW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_SCALE,
    S_CALC,
    S_OUT
  } state_t;

  logic [11:0] map_mem [lgce_pkg::NumPixels];
  logic [23:0] shown_mem [lgce_pkg::NumPixels];
  logic [23:0] prev_mem [lgce_pkg::NumPixels];
  logic [23:0] targ_mem [lgce_pkg::NumPixels];
  logic [23:0] col_r [lgce_pkg::NumGroups];
  logic [lgce_pkg::NumPixels-1:0] shown_v_r, prev_v_r, targ_v_r;

  state_t       state_r;
  lgce_pkg::sweep_req_t cur_r;
  logic [PW:0]  idx_r;
  logic [6:0]   n_r;
  logic [11:0]  map_q_r;
  logic [23:0]  shown_q_r, prev_q_r, targ_q_r;
  logic [7:0]   f_r;
  logic [23:0]  res_r;
  logic [23:0]  col_sel;
  logic [15:0]  fprod;
  logic [23:0]  tgt_calc, blend_calc, prev_eff, targ_eff;
  logic [8:0]   t;
  logic [PW-1:0] ix;

  assign ix = idx_r[PW-1:0];
  assign t = (cur_r.fade > 9'd255) ? 9'd255 : cur_r.fade;
  assign busy = (state_r != S_IDLE);
  assign prev_eff = prev_v_r[ix] ? prev_q_r : 24'd0;
  assign targ_eff = targ_v_r[ix] ? targ_q_r : 24'd0;

  always_comb begin
    col_sel = 24'd0;
    if ({1'b0, map_q_r[11:8]} < 5'(lgce_pkg::NumGroups)) begin
      col_sel = col_r[map_q_r[8+lgce_pkg::GrpW-1:8]];
    end
    fprod = cur_r.bright * map_q_r[7:0];
    for (int c = 0; c < 3; c++) begin
      tgt_calc[c*8 +: 8] = lgce_pkg::div255(16'(col_sel[c*8 +: 8] * f_r));
      blend_calc[c*8 +: 8] = 8'(((18'(prev_eff[c*8 +: 8]) << 8)
        + 18'(targ_eff[c*8 +: 8]) * (18'd1 + 18'(t))
        - 18'(prev_eff[c*8 +: 8]) * 18'(t)) >> 8);
    end
  end

  always_ff @(posedge clk) begin
    if (load_we) begin
      map_mem[load_idx] <= {load_grp, load_prof};
    end
    map_q_r   <= map_mem[ix];
    shown_q_r <= shown_mem[ix];
    prev_q_r  <= prev_mem[ix];
    targ_q_r  <= targ_mem[ix];
    if (state_r == S_CALC && cur_r.kind == lgce_pkg::PASS_BUILD) begin
      if (7'(idx_r) < n_r) targ_mem[ix] <= tgt_calc;
      prev_mem[ix] <= shown_v_r[ix] ? shown_q_r : 24'd0;
    end
    if (state_r == S_OUT && !out_stall) begin
      shown_mem[ix] <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      idx_r     <= '0;
      out_valid <= 1'b0;
      shown_v_r <= '0;
      prev_v_r  <= '0;
      targ_v_r  <= '0;
      for (int g = 0; g < lgce_pkg::NumGroups; g++) col_r[g] <= 24'd0;
    end else begin
      if (col_we) col_r[col_idx] <= col_data;
      case (state_r)
        S_IDLE: begin
          if (req.start) begin
            cur_r <= req;
            n_r   <= (req.count < 7'(lgce_pkg::NumPixels)) ? req.count
                     : 7'(lgce_pkg::NumPixels);
            idx_r <= '0;
            if (req.count != 7'd0 || req.kind == lgce_pkg::PASS_BUILD) state_r <= S_READ;
          end
        end
        S_READ: begin
          // The read for this pixel is issued now; its data arrives next cycle.
          state_r <= (cur_r.kind == lgce_pkg::PASS_BUILD) ? S_SCALE : S_CALC;
        end
        S_SCALE: begin
          f_r     <= lgce_pkg::div255(fprod);
          state_r <= S_CALC;
        end
        S_CALC: begin
          case (cur_r.kind)
            lgce_pkg::PASS_BUILD: begin
              if (7'(idx_r) < n_r) targ_v_r[ix] <= 1'b1;
              prev_v_r[ix] <= 1'b1;
              if (7'(idx_r) + 7'd1 == 7'(lgce_pkg::NumPixels)) begin
                state_r <= S_IDLE;
              end else begin
                idx_r   <= idx_r + 1'b1;
                state_r <= S_READ;
              end
            end
            default: begin
              res_r <= (cur_r.kind == lgce_pkg::PASS_BLEND) ? blend_calc : targ_eff;
              out_pixel  <= 6'(idx_r);
              out_red    <= (cur_r.kind == lgce_pkg::PASS_BLEND) ? blend_calc[7:0]
                            : targ_eff[7:0];
              out_green  <= (cur_r.kind == lgce_pkg::PASS_BLEND) ? blend_calc[15:8]
                            : targ_eff[15:8];
              out_blue   <= (cur_r.kind == lgce_pkg::PASS_BLEND) ? blend_calc[23:16]
                            : targ_eff[23:16];
              frame_last <= (7'(idx_r) + 7'd1 == n_r);
              out_valid  <= 1'b1;
              state_r    <= S_OUT;
            end
          endcase
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            shown_v_r[ix] <= 1'b1;
            if (frame_last) begin
              state_r <= S_IDLE;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_READ;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_OUT)
    else $error("result valid outside output state");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_OUT && frame_last && !out_stall) |=> state_r == S_IDLE)
    else $error("sweep did not end after last pixel");

endmodule

/* rtl/core/led_group_crossfade_engine.sv */
// ----------------------------------------------------------------------------
// LED group cross-fade engine
// Group colors, luminosity and fade sequencing over a pixel memory sweep.
//
// Channel | Direction | Handshake
// in_     | input     | in_valid / in_stall
// out_    | output    | out_valid / out_stall
// cfg_    | input     | cfg_valid / cfg_ready
//
// Non-tick requests and ticks in the idle phase are accepted without a stall.
// A building tick sweeps all 16 memory entries through read, scale and compute,
// and the input stalls until that sweep ends. An emitting tick steps each pixel
// in use through read, compute and output, held by output stalls; when no pixel
// is in use, the registered sweep start still stalls the input after the tick.
// Reset is synchronous; there is no clearing pass. Output stalls hold the sweep.
// ----------------------------------------------------------------------------
module led_group_crossfade_engine (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic       in_active,
  input  logic [3:0] in_group_index,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  input  logic [8:0] in_group_order,
  input  logic [5:0] in_pixel_index,
  input  logic [7:0] in_profile_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [5:0] out_pixel,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_frame_last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_index,
  input  logic [15:0] cfg_data
);

  typedef enum logic [1:0] { PH_IDLE, PH_SCHED, PH_CHANGING, PH_FINISHED } phase_t;
  typedef enum logic [1:0] { LUM_BRIGHT, LUM_DSTART, LUM_DELAY, LUM_DIM } lum_t;

  logic [8:0]  base_r;
  logic [7:0]  step_r, maxb_r, minb_r;
  logic [15:0] delay_r;
  logic [6:0]  cnt_r;
  phase_t      phase_r;
  lum_t        lum_r;
  logic [8:0]  fade_r;
  logic [16:0] dcnt_r;
  logic        busy, acc, tick, pend_r;
  lgce_pkg::sweep_req_t req;
  logic [7:0]  wire_c [3];
  logic [23:0] col_data;
  logic [2:0]  p;
  logic [8:0]  fade_nxt;
  phase_t      phase_nxt;

  assign cfg_ready = 1'b1;
  assign in_stall = busy | pend_r;
  assign acc  = in_valid & ~in_stall;
  assign tick = acc && in_opcode == lgce_pkg::OP_TICK;

  always_comb begin
    wire_c[0] = 8'd0; wire_c[1] = 8'd0; wire_c[2] = 8'd0;
    p = in_group_order[8:6]; if (p < 3'd3) wire_c[p[1:0]] = in_red_in;
    p = in_group_order[5:3]; if (p < 3'd3) wire_c[p[1:0]] = in_green_in;
    p = in_group_order[2:0]; if (p < 3'd3) wire_c[p[1:0]] = in_blue_in;
    if (in_group_order == base_r) begin
      col_data = {in_blue_in, in_green_in, in_red_in};
    end else begin
      col_data[7:0]   = (base_r[8:6] < 3'd3) ? wire_c[base_r[7:6]] : 8'd0;
      col_data[15:8]  = (base_r[5:3] < 3'd3) ? wire_c[base_r[4:3]] : 8'd0;
      col_data[23:16] = (base_r[2:0] < 3'd3) ? wire_c[base_r[1:0]] : 8'd0;
    end
  end

  always_comb begin
    req.start  = tick && phase_r != PH_IDLE;
    req.kind   = (phase_r == PH_SCHED) ? lgce_pkg::PASS_BUILD :
                 (phase_r == PH_CHANGING) ? lgce_pkg::PASS_BLEND : lgce_pkg::PASS_FINAL;
    req.bright = (lum_r == LUM_BRIGHT || lum_r == LUM_DELAY) ? maxb_r : minb_r;
    req.fade   = fade_r;
    req.count  = cnt_r;
    fade_nxt   = fade_r;
    phase_nxt  = phase_r;
    case (phase_r)
      PH_SCHED: begin
        fade_nxt = 9'd0;
        phase_nxt = PH_CHANGING;
      end
      PH_CHANGING: begin
        fade_nxt = ((fade_r > 9'd255) ? 9'd255 : fade_r) + {1'b0, step_r};
        if (fade_nxt >= 9'd255) phase_nxt = PH_FINISHED;
      end
      PH_FINISHED: phase_nxt = PH_IDLE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= 9'd66; step_r <= 8'd16; delay_r <= 16'd100;
      maxb_r <= 8'd255; minb_r <= 8'd0; cnt_r <= 7'd16;
      phase_r <= PH_IDLE; lum_r <= LUM_BRIGHT; fade_r <= 9'd0; dcnt_r <= 17'd0;
      pend_r <= 1'b0;
    end else begin
      pend_r <= req.start;
      if (cfg_valid) begin
        case (cfg_index)
          lgce_pkg::REG_BASE_ORDER: base_r  <= cfg_data[8:0];
          lgce_pkg::REG_FADE_STEP:  step_r  <= cfg_data[7:0];
          lgce_pkg::REG_DELAY:      delay_r <= cfg_data;
          lgce_pkg::REG_MAX_BRIGHT: maxb_r  <= cfg_data[7:0];
          lgce_pkg::REG_MIN_BRIGHT: minb_r  <= cfg_data[7:0];
          lgce_pkg::REG_PIXEL_CNT:  cnt_r   <= cfg_data[6:0];
          default: ;
        endcase
      end
      if (acc) begin
        case (in_opcode)
          lgce_pkg::OP_TICK: begin
            phase_r <= phase_nxt;
            fade_r  <= fade_nxt;
            if (lum_r == LUM_DSTART) begin
              dcnt_r <= 17'd0;
              lum_r  <= LUM_DELAY;
            end else if (lum_r == LUM_DELAY) begin
              if ((dcnt_r + 17'(dcnt_r != 17'h1FFFF)) > {1'b0, delay_r}) begin
                lum_r   <= LUM_DIM;
                phase_r <= PH_SCHED;
              end
              if (dcnt_r != 17'h1FFFF) dcnt_r <= dcnt_r + 17'd1;
            end
          end
          lgce_pkg::OP_ACTIVE: begin
            if (in_active) begin
              lum_r <= LUM_BRIGHT;
              phase_r <= PH_SCHED;
            end else begin
              lum_r <= LUM_DSTART;
            end
          end
          lgce_pkg::OP_COLOR: begin
            if ({1'b0, in_group_index} < 5'(lgce_pkg::NumGroups)) phase_r <= PH_SCHED;
          end
          default: ;
        endcase
      end
    end
  end

  lgce_pix u_pix (
    .clk(clk), .rst_n(rst_n), .req(req),
    .load_we(acc && in_opcode == lgce_pkg::OP_LOAD
             && {1'b0, in_pixel_index} < 7'(lgce_pkg::NumPixels)),
    .load_idx(in_pixel_index[lgce_pkg::PixW-1:0]),
    .load_grp(in_group_index), .load_prof(in_profile_value),
    .col_we(acc && in_opcode == lgce_pkg::OP_COLOR
            && {1'b0, in_group_index} < 5'(lgce_pkg::NumGroups)),
    .col_idx(in_group_index[lgce_pkg::GrpW-1:0]), .col_data(col_data),
    .busy(busy), .out_valid(out_valid), .out_stall(out_stall),
    .out_pixel(out_pixel), .out_red(out_red), .out_green(out_green),
    .out_blue(out_blue), .frame_last(out_frame_last)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    req.start |=> in_stall)
    else $error("request accepted while sweep starting");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request accepted during frame output");
  assert property (@(posedge clk) disable iff (!rst_n)
    (lum_r == LUM_DSTART && tick) |=> lum_r == LUM_DELAY)
    else $error("delay did not start");

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LED group cross-fade engine testbench
// Drives load, color, active and tick requests with random gaps and output
// stalls, predicts each emitted pixel from its own model of the engine and
// compares every result field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int PH_IDLE = 0, PH_SCHED = 1, PH_CHANGING = 2, PH_FINISHED = 3;
  localparam int LUM_BRIGHT = 0, LUM_DELAY_START = 1, LUM_DELAY = 2, LUM_DIM = 3;

  typedef struct packed {
    logic [5:0] pixel;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_opcode = '0;
  logic in_active = 1'b0;
  logic [3:0] in_group_index = '0;
  logic [7:0] in_red_in = '0, in_green_in = '0, in_blue_in = '0;
  logic [8:0] in_group_order = '0;
  logic [5:0] in_pixel_index = '0;
  logic [7:0] in_profile_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] out_pixel;
  logic [7:0] out_red, out_green, out_blue;
  logic out_frame_last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  led_group_crossfade_engine dut (.*);

  always #5 clk = ~clk;

  // Predictor state.
  int unsigned base_order, fade_step, delay_frames, max_bright, min_bright, pix_count;
  logic [7:0] shown[lgce_pkg::NumPixels][3];
  logic [7:0] prev[lgce_pkg::NumPixels][3];
  logic [7:0] target[lgce_pkg::NumPixels][3];
  logic [3:0] pix_group[lgce_pkg::NumPixels];
  logic [7:0] pix_profile[lgce_pkg::NumPixels];
  logic [7:0] group_color[lgce_pkg::NumGroups][3];
  int unsigned phase, fade_pos, lum, delay_count;
  bit loaded[lgce_pkg::NumPixels];

  pixel_result_t expected_pixels[$];
  int mismatches = 0;

  task automatic report(input string what, input int got, input int want);
    $display("%0t: %s got %0d expected %0d", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic int unsigned used_pixels();
    return pix_count < lgce_pkg::NumPixels ? pix_count : lgce_pkg::NumPixels;
  endfunction

  function automatic void push_frame();
    int unsigned n = used_pixels();
    for (int unsigned i = 0; i < n; i++)
      expected_pixels.push_back({i[5:0], shown[i][0], shown[i][1], shown[i][2], i + 1 == n});
  endfunction

  function automatic void predict_tick();
    int unsigned n, br, f, col, v;
    n = used_pixels();
    case (phase)
      PH_SCHED: begin
        prev = shown;
        br = (lum == LUM_BRIGHT || lum == LUM_DELAY) ? max_bright : min_bright;
        for (int i = 0; i < n; i++) begin
          f = (br * pix_profile[i]) / 255;
          for (int c = 0; c < 3; c++) begin
            col = pix_group[i] < lgce_pkg::NumGroups ? group_color[pix_group[i]][c] : 0;
            target[i][c] = 8'((col * f) / 255);
          end
        end
        fade_pos = 0;
        phase = PH_CHANGING;
      end
      PH_CHANGING: begin
        if (fade_pos > 255) fade_pos = 255;
        for (int i = 0; i < n; i++)
          for (int c = 0; c < 3; c++) begin
            v = prev[i][c] * 256 + target[i][c] + target[i][c] * fade_pos
                - prev[i][c] * fade_pos;
            shown[i][c] = 8'(v >> 8);
          end
        push_frame();
        fade_pos = (fade_pos + fade_step) & 'h1ff;
        if (fade_pos >= 255) phase = PH_FINISHED;
      end
      PH_FINISHED: begin
        for (int i = 0; i < n; i++) shown[i] = target[i];
        push_frame();
        phase = PH_IDLE;
      end
      default: ;
    endcase
    if (lum == LUM_DELAY_START) begin
      delay_count = 0;
      lum = LUM_DELAY;
    end else if (lum == LUM_DELAY) begin
      if (delay_count < 'h1ffff) delay_count++;
      if (delay_count > delay_frames) begin
        lum = LUM_DIM;
        phase = PH_SCHED;
      end
    end
  endfunction

  function automatic void predict_color(int unsigned g, int unsigned r, int unsigned gr,
                                        int unsigned b, int unsigned ord);
    logic [7:0] wire_val[3];
    int unsigned p;
    if (g >= lgce_pkg::NumGroups) return;
    if (ord == base_order) begin
      group_color[g][0] = 8'(r);
      group_color[g][1] = 8'(gr);
      group_color[g][2] = 8'(b);
    end else begin
      wire_val = '{0, 0, 0};
      p = (ord >> 6) & 7; if (p < 3) wire_val[p] = 8'(r);
      p = (ord >> 3) & 7; if (p < 3) wire_val[p] = 8'(gr);
      p = ord & 7;        if (p < 3) wire_val[p] = 8'(b);
      for (int c = 0; c < 3; c++) begin
        p = (base_order >> (6 - 3 * c)) & 7;
        group_color[g][c] = p < 3 ? wire_val[p] : 8'd0;
      end
    end
    phase = PH_SCHED;
  endfunction

  function automatic bit pixels_ready();
    for (int i = 0; i < used_pixels(); i++)
      if (!loaded[i]) return 0;
    return 1;
  endfunction

  // Sends one request; a tick is turned into a load when the in-use pixels
  // are not all loaded yet, so that each in-use pixel's map entry is written first.
  task automatic send(input logic [1:0] op, input bit act, input int grp, input int r,
                      input int g, input int b, input int ord, input int pix,
                      input int prof);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (op == lgce_pkg::OP_TICK && !pixels_ready()) begin
      op = lgce_pkg::OP_LOAD;
      for (int i = 0; i < lgce_pkg::NumPixels; i++)
        if (!loaded[i]) begin
          pix = i;
          break;
        end
    end
    in_valid <= 1'b1;
    in_opcode <= op;
    in_active <= act;
    in_group_index <= 4'(grp);
    in_red_in <= 8'(r);
    in_green_in <= 8'(g);
    in_blue_in <= 8'(b);
    in_group_order <= 9'(ord);
    in_pixel_index <= 6'(pix);
    in_profile_value <= 8'(prof);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (op)
      lgce_pkg::OP_TICK: predict_tick();
      lgce_pkg::OP_ACTIVE: begin
        if (act) begin
          lum = LUM_BRIGHT;
          phase = PH_SCHED;
        end else lum = LUM_DELAY_START;
      end
      lgce_pkg::OP_COLOR: predict_color(grp, r, g, b, ord);
      default: begin
        if (pix < lgce_pkg::NumPixels) begin
          pix_group[pix] = 4'(grp);
          pix_profile[pix] = 8'(prof);
          loaded[pix] = 1;
        end
      end
    endcase
  endtask

  task automatic send_random();
    send(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), $urandom_range(0, 15),
         $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255),
         $urandom_range(0, 511), $urandom_range(0, 63), $urandom_range(0, 255));
  endtask

  task automatic tick();
    send(lgce_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0, 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (250) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input int unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 16'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (idx)
      lgce_pkg::REG_BASE_ORDER: base_order = val & 'h1ff;
      lgce_pkg::REG_FADE_STEP:  fade_step = val & 'hff;
      lgce_pkg::REG_DELAY:      delay_frames = val & 'hffff;
      lgce_pkg::REG_MAX_BRIGHT: max_bright = val & 'hff;
      lgce_pkg::REG_MIN_BRIGHT: min_bright = val & 'hff;
      default:                  pix_count = val & 'h7f;
    endcase
  endtask

  task automatic test_load_and_extremes();
    for (int i = 0; i < lgce_pkg::NumPixels; i++)
      send(lgce_pkg::OP_LOAD, 0, i % 2 ? 15 - i % 4 : i % 4, 0, 0, 0, 0, i,
           i == 0 ? 0 : 255 - i);
    send(lgce_pkg::OP_LOAD, 0, 3, 0, 0, 0, 0, 63, 77);
    send(lgce_pkg::OP_COLOR, 0, 0, 255, 255, 255, 66, 0, 0);
    send(lgce_pkg::OP_COLOR, 0, 1, 255, 0, 128, 'o012, 0, 0);
    send(lgce_pkg::OP_COLOR, 0, 2, 1, 2, 3, 'o777, 0, 0);
    send(lgce_pkg::OP_COLOR, 0, 3, 10, 20, 30, 'o000, 0, 0);
    send(lgce_pkg::OP_COLOR, 0, 15, 9, 9, 9, 'o210, 0, 0);
    repeat (4) tick();
    drain();
  endtask

  task automatic test_fade_settings();
    write_reg(lgce_pkg::REG_FADE_STEP, 255);
    write_reg(lgce_pkg::REG_BASE_ORDER, 'o210);
    write_reg(lgce_pkg::REG_PIXEL_CNT, 64);
    send(lgce_pkg::OP_COLOR, 0, 1, 200, 100, 50, 'o201, 0, 0);
    repeat (4) tick();
    drain();
    write_reg(lgce_pkg::REG_FADE_STEP, 3);
    write_reg(lgce_pkg::REG_PIXEL_CNT, 1);
    send(lgce_pkg::OP_COLOR, 0, 2, 255, 0, 255, 'o012, 0, 0);
    repeat (90) tick();
    drain();
    write_reg(lgce_pkg::REG_PIXEL_CNT, 0);
    send(lgce_pkg::OP_COLOR, 0, 0, 1, 1, 1, 'o111, 0, 0);
    repeat (3) tick();
    drain();
  endtask

  task automatic test_dimming();
    write_reg(lgce_pkg::REG_PIXEL_CNT, 4);
    write_reg(lgce_pkg::REG_FADE_STEP, 64);
    write_reg(lgce_pkg::REG_DELAY, 2);
    write_reg(lgce_pkg::REG_MAX_BRIGHT, 0);
    write_reg(lgce_pkg::REG_MIN_BRIGHT, 255);
    send(lgce_pkg::OP_ACTIVE, 1, 0, 0, 0, 0, 0, 0, 0);
    repeat (8) tick();
    send(lgce_pkg::OP_ACTIVE, 0, 0, 0, 0, 0, 0, 0, 0);
    repeat (12) tick();
    drain();
    write_reg(lgce_pkg::REG_DELAY, 65535);
    write_reg(lgce_pkg::REG_MAX_BRIGHT, 255);
    write_reg(lgce_pkg::REG_MIN_BRIGHT, 0);
    send(lgce_pkg::OP_ACTIVE, 0, 0, 0, 0, 0, 0, 0, 0);
    repeat (3) tick();
    drain();
  endtask

  task automatic test_random();
    write_reg(lgce_pkg::REG_DELAY, 0);
    write_reg(lgce_pkg::REG_FADE_STEP, 40);
    write_reg(lgce_pkg::REG_PIXEL_CNT, 16);
    for (int k = 0; k < 130; k++) begin
      if (k == 65) begin
        drain();
        write_reg(lgce_pkg::REG_BASE_ORDER, 511);
        write_reg(lgce_pkg::REG_DELAY, 5);
        write_reg(lgce_pkg::REG_PIXEL_CNT, 9);
      end
      if ($urandom_range(0, 1)) tick();
      else send_random();
    end
    drain();
  endtask

  // Result checker with random stalls.
  initial begin
    pixel_result_t want;
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) report("unexpected result pixel", out_pixel, -1);
        else begin
          want = expected_pixels.pop_front();
          if (out_pixel !== want.pixel) report("pixel", out_pixel, want.pixel);
          if (out_red !== want.red) report("red", out_red, want.red);
          if (out_green !== want.green) report("green", out_green, want.green);
          if (out_blue !== want.blue) report("blue", out_blue, want.blue);
          if (out_frame_last !== want.last) report("frame_last", out_frame_last, want.last);
        end
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if ($urandom_range(0, 7) == 0) hold = $urandom_range(0, 14);
      end
    end
  end

  initial begin
    #80ms;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    base_order = 66; fade_step = 16; delay_frames = 100;
    max_bright = 255; min_bright = 0; pix_count = 16;
    shown = '{default: '{default: '0}};
    prev = shown;
    target = shown;
    group_color = '{default: '{default: '0}};
    pix_group = '{default: '0};
    pix_profile = '{default: '0};
    loaded = '{default: 0};
    phase = PH_IDLE; fade_pos = 0; lum = LUM_BRIGHT; delay_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_and_extremes();
    test_fade_settings();
    test_dimming();
    test_random();
    if (mismatches == 0 && expected_pixels.size() == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule

/* sim.f */
rtl/core/lgce_pkg.sv
rtl/core/lgce_pix.sv
rtl/core/led_group_crossfade_engine.sv
verif/tb.sv
